@@ rtl/core/smv_pkg.sv @@
// ----------------------------------------------------------------------------
// smv_pkg: shared definitions for the sample mean and variance block
// Sizes, sequencer states, status codes and the divider request types.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned SUM_W       = SAMPLE_W + ADDR_W;
  localparam int unsigned SQ_W        = 2 * SAMPLE_W;
  localparam int unsigned ACC_W       = SQ_W + ADDR_W;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned DIVD_W      = ACC_W - FRAC_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVD_W);
  localparam int unsigned VAR_W       = 63;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_W       = SAMPLE_W + VAR_W + CNT_W;
  localparam int unsigned OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN,
    ST_PASS,
    ST_VAR_GO,
    ST_VAR,
    ST_DONE
  } smv_state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } smv_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } smv_div_rsp_t;

endpackage

@@ rtl/core/smv_div.sv @@
// ----------------------------------------------------------------------------
// smv_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by the mean and
// the variance steps. The quotient is valid when done pulses.
// ----------------------------------------------------------------------------
module smv_div
  import smv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  smv_div_req_t req_i,
  output smv_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_sub;
  logic                 fits;

  assign trial     = {rem_q, quo_q[DIVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits its width.
      rem_d = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/core/sample_mean_variance_top.sv @@
// ----------------------------------------------------------------------------
// sample_mean_variance_top: two-pass sample mean and unbiased variance
// Stores a set of Q16.16 samples and reports mean, variance, count, status.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the slave stream, one request per sample, with tlast on
// the final sample of a set. While a set is loading the block takes one
// sample per cycle and writes it to a 1024-entry store with one write and
// one read port; samples beyond the store are dropped and reported as an
// overflow status. After the last sample tready falls. The shared serial
// divider forms the mean, a second pass reads the store once per cycle
// through a three-stage difference, square and accumulate pipeline, and
// the divider runs again for the variance. The store's read port and the
// one-bit-a-cycle divider set how long it takes from the last sample to
// the result. The result sits in an output register. If the receiver
// stalls, the next set may still load; its computation finishes and then
// waits until the previous result has been taken. Reset empties the set
// and drops any pending result; the store itself is not cleared.
// ----------------------------------------------------------------------------
module sample_mean_variance_top
  import smv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata_i,   // [31:0] sample
  input  logic                   s_axis_tlast_i,   // last sample of the set
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_BYTES_W-1:0] m_axis_tdata_o,   // mean, variance, sample_count
  output logic [STATUS_W-1:0]    m_axis_tuser_o    // status
);

  smv_state_e         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               v1_q, v2_q, v3_q;
  logic               issue;
  logic               accept;
  logic               store_wr;
  logic               out_valid_q, out_valid_d;
  logic               load_out;

  logic [SAMPLE_W-1:0] store_q [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [SAMPLE_W-1:0] absd_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic [DIVD_W-1:0]   var_q;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   diff_abs;
  logic [SUM_W-1:0]    sum_abs;
  logic [SAMPLE_W-1:0] quo_lo;

  logic [SAMPLE_W-1:0] out_mean_q;
  logic [VAR_W-1:0]    out_var_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [STATUS_W-1:0] status;

  smv_div_req_t div_req;
  smv_div_rsp_t div_rsp;

  smv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign store_wr        = accept && (count_q < CNT_W'(MAX_SAMPLES));
  assign issue           = (state_q == ST_PASS) && (rd_cnt_q != count_q);
  assign load_out        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  assign sum_abs  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign quo_lo   = div_rsp.quotient[SAMPLE_W-1:0];
  assign diff     = {rdata_q[SAMPLE_W-1], rdata_q} - {mean_q[SAMPLE_W-1], mean_q};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  always_comb begin
    priority if (ovf_q) begin
      status = STATUS_OVERFLOW;
    end else if (count_q < CNT_W'(2)) begin
      status = STATUS_TOO_FEW;
    end else begin
      status = STATUS_OK;
    end
  end

  // Sequencer: loading, mean division, second pass, variance division, result hand-off.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sum_d    = sum_q;
    ovf_d    = ovf_q;
    rd_cnt_d = rd_cnt_q;
    div_req.start    = 1'b0;
    div_req.dividend = DIVD_W'(sum_abs);
    div_req.divisor  = count_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (store_wr) begin
            count_d = count_q + 1'b1;
            sum_d   = sum_q + {{(SUM_W-SAMPLE_W){s_axis_tdata_i[SAMPLE_W-1]}},
                               s_axis_tdata_i};
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = ST_MEAN_GO;
          end
        end
      end
      ST_MEAN_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_MEAN;
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          rd_cnt_d = '0;
          state_d  = (count_q < CNT_W'(2)) ? ST_DONE : ST_PASS;
        end
      end
      ST_PASS: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc_q[ACC_W-1:FRAC_W];
        div_req.divisor  = count_q - 1'b1;
        state_d          = ST_VAR;
      end
      ST_VAR: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      rd_cnt_q    <= rd_cnt_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample store: written while loading, read once per cycle in the second pass.
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[count_q[ADDR_W-1:0]] <= s_axis_tdata_i;
    end
    rdata_q <= store_q[rd_cnt_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    absd_q <= diff_abs[SAMPLE_W-1:0];
    sq_q   <= absd_q * absd_q;
    if (state_q == ST_MEAN_GO) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end
    if ((state_q == ST_MEAN) && div_rsp.done) begin
      // The quotient is the magnitude; the sign of the sum gives truncation toward zero.
      mean_q <= sum_q[SUM_W-1] ? (~quo_lo + 1'b1) : quo_lo;
      var_q  <= '0;
    end
    if ((state_q == ST_VAR) && div_rsp.done) begin
      var_q <= div_rsp.quotient;
    end
    if (load_out) begin
      out_mean_q   <= mean_q;
      out_var_q    <= VAR_W'(var_q);
      out_cnt_q    <= count_q;
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_BYTES_W-OUT_W){1'b0}}, out_cnt_q, out_var_q, out_mean_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

@@ rtl/core/smv_checker.sv @@
// ----------------------------------------------------------------------------
// smv_checker: port-level checks for the sample mean and variance block
// Watches the streams of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module smv_checker
  import smv_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   s_axis_tlast_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_BYTES_W-1:0] m_axis_tdata_o,
  input logic [STATUS_W-1:0]    m_axis_tuser_o
);

  // A stalled result must not change under the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Computation starts at the last sample, so the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input still open after the last sample");

  // A too-few result comes from exactly one sample and carries no variance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == STATUS_TOO_FEW)) |->
      ((m_axis_tdata_o[94:32] == '0) && (m_axis_tdata_o[105:95] == 11'd1)))
    else $error("too-few result with wrong count or variance");

  // An ok result needs at least two samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == STATUS_OK)) |->
      (m_axis_tdata_o[105:95] >= 11'd2))
    else $error("ok result with fewer than two samples");

  // Status never takes the unused code, and the padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o != 2'd3) &&
      (m_axis_tdata_o[OUT_BYTES_W-1:OUT_W] == '0)))
    else $error("bad status code or padding");

endmodule

bind sample_mean_variance_top smv_checker u_smv_checker (.*);
